@@ hw/rtl/gds_pkg.sv @@
package gds_pkg;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_RANGE   = 2'd2
    } status_t;

    // step direction codes
    localparam logic MODE_FWD  = 1'b0;
    localparam logic MODE_BACK = 1'b1;

    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [3:0]  MONTH_MAX = 4'd12;
    localparam logic [4:0]  DAY_MAX   = 5'd31;

    // floor(y / 100) as (y * RECIP_100) >> RECIP_SHIFT, exact for 14-bit y
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam logic [7:0]  CENTURY     = 8'd100;

    // days in month m, month codes outside 1..12 give 31
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ hw/rtl/gds_in_if.sv @@
interface gds_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [13:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;

    modport source (output valid, output mode, output in_year, output in_month,
                    output in_day, input ready);
    modport sink   (input valid, input mode, input in_year, input in_month,
                    input in_day, output ready);
endinterface

@@ hw/rtl/gds_out_if.sv @@
interface gds_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [1:0]  status;

    modport source (output valid, output out_year, output out_month, output out_day,
                    output status, input ready);
    modport sink   (input valid, input out_year, input out_month, input out_day,
                    input status, output ready);
endinterface

@@ hw/rtl/gregorian_date_step.sv @@
// a request passes through the stage 1, stage 2 and stage 3 registers before its result reaches the output
// throughput: one request per cycle; an output stall holds only the full stages
// the stage depth is set by the divide-by-100 reciprocal multiply and the day compare
// reset clears the stage valid bits only; payload registers are not reset
module gregorian_date_step
    import gds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gds_in_if.sink    in_ch,
    gds_out_if.source out_ch
);

    // stage enables, a stage loads when it is empty or its content moves on
    logic en1, en2, en3;

    // stage 1 registers
    logic        v1_reg;
    logic        mode1_reg;
    logic [13:0] y1_reg;
    logic [3:0]  m1_reg;
    logic [4:0]  d1_reg;
    logic [7:0]  q1_reg;

    // stage 2 registers
    logic        v2_reg;
    logic        mode2_reg;
    logic [13:0] y2_reg;
    logic [3:0]  m2_reg;
    logic [4:0]  d2_reg;
    logic [4:0]  mlen2_reg;
    logic [4:0]  plen2_reg;
    logic        inv2_reg;

    // stage 3 (output) registers
    logic        v3_reg;
    logic [13:0] y3_reg;
    logic [3:0]  m3_reg;
    logic [4:0]  d3_reg;
    status_t     st3_reg;

    logic [26:0] prod;
    logic [7:0]  q_next;
    logic [13:0] r100;
    logic        leap;
    logic [4:0]  mlen_next;
    logic [4:0]  plen_next;
    logic        inv_next;
    logic [13:0] y3_next;
    logic [3:0]  m3_next;
    logic [4:0]  d3_next;
    status_t     st3_next;

    // pipeline flow control
    assign en3         = !v3_reg || out_ch.ready;
    assign en2         = !v2_reg || en3;
    assign en1         = !v1_reg || en2;
    assign in_ch.ready = en1;

    // stage 1: quotient of year by 100
    assign prod   = {13'd0, in_ch.in_year} * {14'd0, RECIP_100};
    assign q_next = prod[RECIP_SHIFT +: 8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mode1_reg <= in_ch.mode;
            y1_reg    <= in_ch.in_year;
            m1_reg    <= in_ch.in_month;
            d1_reg    <= in_ch.in_day;
            q1_reg    <= q_next;
        end
    end

    // stage 2: leap year, month lengths, input check
    always_comb
    begin
        r100      = y1_reg - 14'({6'd0, q1_reg} * {6'd0, CENTURY});
        leap      = (y1_reg[1:0] == 2'd0) && ((r100 != 14'd0) || (q1_reg[1:0] == 2'd0));
        mlen_next = month_len(leap, m1_reg);
        plen_next = month_len(leap, m1_reg - 4'd1);
        inv_next  = (y1_reg > YEAR_MAX) || (m1_reg == 4'd0) || (m1_reg > MONTH_MAX)
                    || (d1_reg == 5'd0) || (d1_reg > mlen_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            mode2_reg <= mode1_reg;
            y2_reg    <= y1_reg;
            m2_reg    <= m1_reg;
            d2_reg    <= d1_reg;
            mlen2_reg <= mlen_next;
            plen2_reg <= plen_next;
            inv2_reg  <= inv_next;
        end
    end

    // stage 3: day step with month and year roll over
    always_comb
    begin
        y3_next  = y2_reg;
        m3_next  = m2_reg;
        d3_next  = d2_reg;
        st3_next = STATUS_OK;
        if (inv2_reg)
        begin
            st3_next = STATUS_INVALID;
        end
        else if (mode2_reg == MODE_FWD)
        begin
            if (d2_reg < mlen2_reg)
            begin
                d3_next = d2_reg + 5'd1;
            end
            else if (m2_reg < MONTH_MAX)
            begin
                m3_next = m2_reg + 4'd1;
                d3_next = 5'd1;
            end
            else if (y2_reg < YEAR_MAX)
            begin
                y3_next = y2_reg + 14'd1;
                m3_next = 4'd1;
                d3_next = 5'd1;
            end
            else
            begin
                st3_next = STATUS_RANGE;
            end
        end
        else
        begin
            if (d2_reg > 5'd1)
            begin
                d3_next = d2_reg - 5'd1;
            end
            else if (m2_reg > 4'd1)
            begin
                m3_next = m2_reg - 4'd1;
                d3_next = plen2_reg;
            end
            else if (y2_reg > 14'd0)
            begin
                y3_next = y2_reg - 14'd1;
                m3_next = MONTH_MAX;
                d3_next = DAY_MAX;
            end
            else
            begin
                st3_next = STATUS_RANGE;
            end
        end
        // errors pass the input date through
        if (st3_next != STATUS_OK)
        begin
            y3_next = y2_reg;
            m3_next = m2_reg;
            d3_next = d2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            y3_reg  <= y3_next;
            m3_reg  <= m3_next;
            d3_reg  <= d3_next;
            st3_reg <= st3_next;
        end
    end

    // output drive
    assign out_ch.valid     = v3_reg;
    assign out_ch.out_year  = y3_reg;
    assign out_ch.out_month = m3_reg;
    assign out_ch.out_day   = d3_reg;
    assign out_ch.status    = st3_reg;

    // a full pipeline under stall takes no new request
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && !out_ch.ready) |-> !in_ch.ready)
        else $error("request taken while pipeline is full and stalled");

    // an ok result always holds a month in 1..12, a nonzero day and a year no greater than YEAR_MAX
    a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && st3_reg == STATUS_OK) |->
        (m3_reg >= 4'd1 && m3_reg <= MONTH_MAX && d3_reg >= 5'd1 && y3_reg <= YEAR_MAX))
        else $error("ok result with illegal date");

    // a range error only happens at the two ends of the year range
    a_range_end: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && st3_reg == STATUS_RANGE) |->
        ((y3_reg == YEAR_MAX && m3_reg == MONTH_MAX && d3_reg == DAY_MAX)
         || (y3_reg == 14'd0 && m3_reg == 4'd1 && d3_reg == 5'd1)))
        else $error("range error away from the year range ends");

endmodule
